// ===== src/hsb_to_rgb_converter_core_defines.svh =====
// Assertion macros shared by the verification files of the HSB to RGB converter.
// Depends on nothing; included by the checker file.
`ifndef HSB_TO_RGB_CONVERTER_CORE_DEFINES_SVH
`define HSB_TO_RGB_CONVERTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, quiet during reset.
`define HSB2RGB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, quiet during reset.
`define HSB2RGB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/hsb2rgb_pkg.sv =====
// Shared constants and types of the HSB to RGB converter.
// Depends on nothing; used by the interfaces, the core and its checker.
`timescale 1ns / 1ps

package hsb2rgb_pkg;

  // Default fixed point formats: 2**DefColorBits means 1.0, hue carries
  // DefHueFracBits fraction bits.
  localparam int unsigned DefColorBits   = 12;
  localparam int unsigned DefHueFracBits = 6;

  localparam int unsigned StatusW = 2;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_SAT  = 2'd1,
    ST_HUE_RANGE = 2'd2
  } status_e;

endpackage

// ===== src/hsb2rgb_if.sv =====
// Request and response channel interfaces of the HSB to RGB converter.
// Depends on hsb2rgb_pkg for default widths.
`timescale 1ns / 1ps

interface hsb2rgb_req_if #(
  parameter int unsigned ColorBits   = hsb2rgb_pkg::DefColorBits,
  parameter int unsigned HueFracBits = hsb2rgb_pkg::DefHueFracBits
);
  logic                     valid;
  logic                     ready;
  logic [HueFracBits+8:0]   hue;
  logic                     hue_undefined;
  logic [ColorBits:0]       saturation;
  logic [ColorBits:0]       brightness;

  modport source (output valid, hue, hue_undefined, saturation, brightness, input ready);
  modport sink   (input valid, hue, hue_undefined, saturation, brightness, output ready);
endinterface

interface hsb2rgb_rsp_if #(
  parameter int unsigned ColorBits = hsb2rgb_pkg::DefColorBits
);
  logic                            valid;
  logic                            ready;
  logic [ColorBits:0]              red;
  logic [ColorBits:0]              green;
  logic [ColorBits:0]              blue;
  logic [hsb2rgb_pkg::StatusW-1:0] status;

  modport source (output valid, red, green, blue, status, input ready);
  modport sink   (input valid, red, green, blue, status, output ready);
endinterface

// ===== src/hsb_to_rgb_converter_core.sv =====
// An accepted request passes stages 1 to 6 in turn; stage 6 is the output register.
// Throughput: one request per cycle unless the output stalls; six-stage pipeline with
// per-stage valid bits; a stalled output holds only full stages, bubbles fill up behind it.
// Reset (rst_ni low, asynchronous) clears the valid bits; data registers are not reset.
// Depends on hsb2rgb_pkg and the channel interfaces in hsb2rgb_if.sv.
`timescale 1ns / 1ps

module hsb_to_rgb_converter_core #(
  parameter int unsigned ColorBits   = hsb2rgb_pkg::DefColorBits,
  parameter int unsigned HueFracBits = hsb2rgb_pkg::DefHueFracBits
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  hsb2rgb_req_if.sink    req_i,
  hsb2rgb_rsp_if.source  rsp_o
);
  import hsb2rgb_pkg::*;

  // Fixed point formats. One color unit is 2**ColorBits; hue is degrees with
  // HueFracBits fraction bits, so a sextant spans 60 * 2**HueFracBits codes.
  localparam int unsigned HueW   = HueFracBits + 9;
  localparam int unsigned ColW   = ColorBits + 1;
  localparam int unsigned SextD  = 60 << HueFracBits;
  localparam int unsigned RemW   = $clog2(SextD);
  localparam int unsigned NumStg = 6;

  localparam logic [ColW-1:0] One     = ColW'(1) << ColorBits;
  localparam logic [HueW-1:0] HueFull = HueW'(360 << HueFracBits);

  // The sextant fraction f = floor(rem * 2**ColorBits / SextD) is formed with a
  // reciprocal. With RecM = floor(2**(ColorBits+RemW) / SextD) the estimate
  // (rem * RecM) >> RemW is never high and at most one low, since rem < 2**RemW.
  // One compare against the exact remainder fixes it.
  localparam int unsigned  RecK   = ColorBits + RemW;
  localparam logic [63:0]  RecM64 = (64'd1 << RecK) / 64'(SextD);
  localparam logic [ColW-1:0] RecM = RecM64[ColW-1:0];
  localparam int unsigned  ProdW  = RemW + ColW;
  localparam int unsigned  NumW   = RemW + ColorBits;

  // Side information that travels with every item down the pipeline.
  typedef struct packed {
    logic [2:0] sext;
    status_e    status;
    logic       grey;
  } ctl_t;

  // Product of two values at most 1.0, rounded half up.
  function automatic logic [ColW-1:0] fx_mul(input logic [ColW-1:0] x,
                                             input logic [ColW-1:0] y);
    logic [2*ColW-1:0] prod;
    prod = (2*ColW)'(x) * (2*ColW)'(y) + ((2*ColW)'(1) << (ColorBits - 1));
    return prod[ColorBits +: ColW];
  endfunction

  // ---------------------------------------------------------------------------
  // Pipeline control. Stage k may load when it is empty or when its content moves
  // on; the chain starts at the output register and runs back to the request side.
  // ---------------------------------------------------------------------------
  logic [NumStg-1:0] vld_q;
  logic [NumStg-1:0] adv;

  always_comb begin
    adv[NumStg-1] = !vld_q[NumStg-1] || rsp_o.ready;
    for (int k = NumStg - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= req_i.valid;
      end
      for (int k = 1; k < NumStg; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign req_i.ready = adv[0];
  assign rsp_o.valid = vld_q[NumStg-1];

  // ---------------------------------------------------------------------------
  // Stage 1: clamp saturation and brightness, sort out the special cases, fold a
  // hue of 360 degrees to 0 and split the hue into sextant and remainder by
  // comparing against the five sextant boundaries in parallel.
  // ---------------------------------------------------------------------------
  logic [ColW-1:0] s1_sat_d, s1_val_d;
  logic [HueW-1:0] s1_hwrap;
  logic [HueW-1:0] s1_base;
  ctl_t            s1_ctl_d;

  always_comb begin
    s1_sat_d = (req_i.saturation > One) ? One : req_i.saturation;
    s1_val_d = (req_i.brightness > One) ? One : req_i.brightness;
    s1_hwrap = (req_i.hue == HueFull) ? '0 : req_i.hue;

    s1_ctl_d.sext = '0;
    s1_base       = '0;
    for (int k = 1; k < 6; k++) begin
      if (s1_hwrap >= HueW'(k * SextD)) begin
        s1_ctl_d.sext = 3'(k);
        s1_base       = HueW'(k * SextD);
      end
    end

    // Zero saturation wins over the hue checks. An undefined hue is only valid
    // for grey; with any saturation it counts as out of range.
    s1_ctl_d.grey = 1'b0;
    if (req_i.saturation == '0) begin
      s1_ctl_d.status = req_i.hue_undefined ? ST_OK : ST_ZERO_SAT;
      s1_ctl_d.grey   = req_i.hue_undefined;
    end else if (req_i.hue_undefined || (req_i.hue > HueFull)) begin
      s1_ctl_d.status = ST_HUE_RANGE;
    end else begin
      s1_ctl_d.status = ST_OK;
    end
  end

  logic [ColW-1:0] s1_sat_q, s1_val_q;
  logic [RemW-1:0] s1_rem_q;
  ctl_t            s1_ctl_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s1_sat_q <= s1_sat_d;
      s1_val_q <= s1_val_d;
      s1_rem_q <= RemW'(s1_hwrap - s1_base);
      s1_ctl_q <= s1_ctl_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: multiply the remainder by the reciprocal of the sextant width.
  // ---------------------------------------------------------------------------
  logic [ProdW-1:0] s2_prod_q;
  logic [RemW-1:0]  s2_rem_q;
  logic [ColW-1:0]  s2_sat_q, s2_val_q;
  ctl_t             s2_ctl_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s2_prod_q <= ProdW'(s1_rem_q) * ProdW'(RecM);
      s2_rem_q  <= s1_rem_q;
      s2_sat_q  <= s1_sat_q;
      s2_val_q  <= s1_val_q;
      s2_ctl_q  <= s1_ctl_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: correct the fraction estimate. The sextant width is a constant, so
  // the back-multiplication is shifts and adds.
  // ---------------------------------------------------------------------------
  logic [ColorBits-1:0] s3_fest;
  logic [NumW-1:0]      s3_resid;
  logic                 s3_corr;

  always_comb begin
    s3_fest  = s2_prod_q[RemW +: ColorBits];
    s3_resid = {s2_rem_q, ColorBits'(0)} - NumW'(s3_fest) * NumW'(SextD);
    s3_corr  = s3_resid >= NumW'(SextD);
  end

  logic [ColorBits-1:0] s3_frac_q;
  logic [ColW-1:0]      s3_sat_q, s3_val_q;
  ctl_t                 s3_ctl_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s3_frac_q <= s3_fest + ColorBits'(s3_corr);
      s3_sat_q  <= s2_sat_q;
      s3_val_q  <= s2_val_q;
      s3_ctl_q  <= s2_ctl_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: s*f, s*(1-f) and p = v*(1-s), three multipliers side by side.
  // ---------------------------------------------------------------------------
  logic [ColW-1:0] s4_sf_q, s4_sfc_q, s4_p_q, s4_val_q;
  ctl_t            s4_ctl_q;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      s4_sf_q  <= fx_mul(s3_sat_q, ColW'(s3_frac_q));
      s4_sfc_q <= fx_mul(s3_sat_q, One - ColW'(s3_frac_q));
      s4_p_q   <= fx_mul(s3_val_q, One - s3_sat_q);
      s4_val_q <= s3_val_q;
      s4_ctl_q <= s3_ctl_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: q = v*(1-s*f) and t = v*(1-s*(1-f)).
  // ---------------------------------------------------------------------------
  logic [ColW-1:0] s5_q_q, s5_t_q, s5_p_q, s5_val_q;
  ctl_t            s5_ctl_q;

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      s5_q_q   <= fx_mul(s4_val_q, One - s4_sf_q);
      s5_t_q   <= fx_mul(s4_val_q, One - s4_sfc_q);
      s5_p_q   <= s4_p_q;
      s5_val_q <= s4_val_q;
      s5_ctl_q <= s4_ctl_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: route v, p, q and t to the channels by sextant, or substitute grey
  // or black for the special cases, into the output register.
  // ---------------------------------------------------------------------------
  logic [ColW-1:0] s6_red_d, s6_grn_d, s6_blu_d;

  always_comb begin
    if (s5_ctl_q.status != ST_OK) begin
      s6_red_d = '0;
      s6_grn_d = '0;
      s6_blu_d = '0;
    end else if (s5_ctl_q.grey) begin
      s6_red_d = s5_val_q;
      s6_grn_d = s5_val_q;
      s6_blu_d = s5_val_q;
    end else begin
      case (s5_ctl_q.sext)
        3'd0: begin
          s6_red_d = s5_val_q; s6_grn_d = s5_t_q;   s6_blu_d = s5_p_q;
        end
        3'd1: begin
          s6_red_d = s5_q_q;   s6_grn_d = s5_val_q; s6_blu_d = s5_p_q;
        end
        3'd2: begin
          s6_red_d = s5_p_q;   s6_grn_d = s5_val_q; s6_blu_d = s5_t_q;
        end
        3'd3: begin
          s6_red_d = s5_p_q;   s6_grn_d = s5_q_q;   s6_blu_d = s5_val_q;
        end
        3'd4: begin
          s6_red_d = s5_t_q;   s6_grn_d = s5_p_q;   s6_blu_d = s5_val_q;
        end
        default: begin
          s6_red_d = s5_val_q; s6_grn_d = s5_p_q;   s6_blu_d = s5_q_q;
        end
      endcase
    end
  end

  logic [ColW-1:0] s6_red_q, s6_grn_q, s6_blu_q;
  status_e         s6_status_q;

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      s6_red_q    <= s6_red_d;
      s6_grn_q    <= s6_grn_d;
      s6_blu_q    <= s6_blu_d;
      s6_status_q <= s5_ctl_q.status;
    end
  end

  assign rsp_o.red    = s6_red_q;
  assign rsp_o.green  = s6_grn_q;
  assign rsp_o.blue   = s6_blu_q;
  assign rsp_o.status = s6_status_q;

endmodule

// ===== src/hsb2rgb_checker.sv =====
// Port-level checks of the HSB to RGB converter, bound to the core.
// Depends on hsb2rgb_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "hsb_to_rgb_converter_core_defines.svh"

module hsb2rgb_checker #(
  parameter int unsigned ColorBits = hsb2rgb_pkg::DefColorBits
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            req_ready_i,
  input logic                            rsp_valid_i,
  input logic                            rsp_ready_i,
  input logic [ColorBits:0]              red_i,
  input logic [ColorBits:0]              green_i,
  input logic [ColorBits:0]              blue_i,
  input logic [hsb2rgb_pkg::StatusW-1:0] status_i
);
  import hsb2rgb_pkg::*;

  localparam logic [ColorBits:0] One = (ColorBits + 1)'(1) << ColorBits;

  // A stalled response keeps its whole payload.
  `HSB2RGB_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(red_i) && $stable(green_i) && $stable(blue_i) && $stable(status_i), "response changed while stalled")

  // With the output register empty no stage can be blocked, so a request is taken.
  `HSB2RGB_ASSERT_NOW(a_req_ready, clk_i, rst_ni, !rsp_valid_i, req_ready_i, "request refused while the output is empty")

  // Any error status comes with a black color.
  `HSB2RGB_ASSERT_NOW(a_err_black, clk_i, rst_ni, rsp_valid_i && (status_i != ST_OK), (red_i == '0) && (green_i == '0) && (blue_i == '0), "error response with nonzero color")

  // Every channel stays within 0 to 1.0.
  `HSB2RGB_ASSERT_NOW(a_color_range, clk_i, rst_ni, rsp_valid_i, (red_i <= One) && (green_i <= One) && (blue_i <= One), "color channel above 1.0")

endmodule

bind hsb_to_rgb_converter_core hsb2rgb_checker #(
  .ColorBits(ColorBits)
) u_hsb2rgb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .red_i       (rsp_o.red),
  .green_i     (rsp_o.green),
  .blue_i      (rsp_o.blue),
  .status_i    (rsp_o.status)
);
